/* rtl/mts_pkg.sv */
// Shared constants, codes and types for the multi-timer scheduler.
`timescale 1ns / 1ps

package mts_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int SLOT_W     = $clog2(MAX_TIMERS);
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int ID_W       = 8;
    localparam int ID_LIMIT   = 255;
    localparam int TRY_W      = ID_W + 1;
    localparam int TIME_W     = 48;
    localparam int DELAY_W    = 31;
    localparam int LIMIT_W    = 32;

    // Command codes.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_REARM = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_POLL  = 2'd3;

    // Result kind codes.
    localparam logic [2:0] KIND_STARTED    = 3'd0;
    localparam logic [2:0] KIND_START_FAIL = 3'd1;
    localparam logic [2:0] KIND_FIRED      = 3'd2;
    localparam logic [2:0] KIND_POLL_DONE  = 3'd3;
    localparam logic [2:0] KIND_ACK        = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_RS    = 4'b0100,
        S_POLL  = 4'b1000
    } t_state;

endpackage

/* rtl/multi_timer_scheduler.sv */
// Timer table with start, rearm, stop and poll commands, run by a small sequencer.
//
//  channel   handshake                      payload
//  command   i_start in, o_busy out         i_command, i_now_ms, i_timer_id, i_delay_ms,
//                                           i_period_ms, i_timeout_limit
//  result    o_valid out, one-cycle strobe  o_kind, o_result_id, o_found, o_next_timeout,
//                                           o_fired_count, o_last
//
// Rearm and stop finish in S_RS. Start retries in S_START once per id that is
// already taken, then commits or fails. Poll walks the age ranks one slot a cycle
// through one shared fire/compare unit, then completes the last wait check and
// reports the poll result.
// Reset clears the slot valid bits and the count; no clearing pass is needed.
// The receiver cannot stall; o_busy is high while the sequencer is out of S_IDLE and falls as the final result appears.
`timescale 1ns / 1ps

module multi_timer_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [1:0]                          i_command,
    input  logic [mts_pkg::TIME_W-1:0]          i_now_ms,
    input  logic [mts_pkg::ID_W-1:0]            i_timer_id,
    input  logic [mts_pkg::DELAY_W-1:0]         i_delay_ms,
    input  logic [mts_pkg::DELAY_W-1:0]         i_period_ms,
    input  logic signed [mts_pkg::LIMIT_W-1:0]  i_timeout_limit,
    output logic                                o_busy,
    output logic                                o_valid,
    output logic [2:0]                          o_kind,
    output logic [mts_pkg::ID_W-1:0]            o_result_id,
    output logic                                o_found,
    output logic signed [mts_pkg::LIMIT_W-1:0]  o_next_timeout,
    output logic [mts_pkg::CNT_W-1:0]           o_fired_count,
    output logic                                o_last
);
    import mts_pkg::*;

    // Timer table; rank 0 is the newest timer.
    logic [MAX_TIMERS-1:0] r_used;
    logic [ID_W-1:0]       r_id       [MAX_TIMERS];
    logic [TIME_W-1:0]     r_deadline [MAX_TIMERS];
    logic [DELAY_W-1:0]    r_period   [MAX_TIMERS];
    logic [SLOT_W-1:0]     r_rank     [MAX_TIMERS];
    logic [CNT_W-1:0]      r_count;

    // Latched command item and sequencer state.
    t_state                      r_state;
    logic [1:0]                  r_cmd;
    logic [TIME_W-1:0]           r_now;
    logic [ID_W-1:0]             r_tid;
    logic [DELAY_W-1:0]          r_delay;
    logic [DELAY_W-1:0]          r_per;
    logic [ID_W-1:0]             r_try_id;
    logic [TRY_W-1:0]            r_tries;
    logic [CNT_W-1:0]            r_pos;
    logic [CNT_W-1:0]            r_fired;
    logic signed [LIMIT_W-1:0]   r_nt;
    logic                        r_due;
    logic                        r_ev_valid;
    logic [TIME_W-1:0]           r_ev_dl;

    logic                        accept;
    logic [ID_W-1:0]             oldest_id;
    logic [SLOT_W-1:0]           oldest_rank;
    logic [SLOT_W-1:0]           free_slot;
    logic                        try_taken;
    logic                        tid_hit;
    logic [SLOT_W-1:0]           tid_slot;
    logic [SLOT_W-1:0]           poll_slot;
    logic [TIME_W-1:0]           poll_dl;
    logic                        poll_fire;
    logic [TIME_W-1:0]           poll_new_dl;
    logic [TIME_W-1:0]           start_dl;
    logic [TIME_W-1:0]           ev_wait;
    logic                        ev_less;
    logic [ID_W-1:0]             next_try;

    // Adds with saturation at the largest deadline.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [DELAY_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + (TIME_W + 1)'(b);
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // Parallel lookups across the slots.
    assign oldest_rank = SLOT_W'(r_count - CNT_W'(1));
    always_comb begin
        oldest_id = '0;
        free_slot = '0;
        try_taken = 1'b0;
        tid_hit   = 1'b0;
        tid_slot  = '0;
        poll_slot = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
        for (int i = 0; i < MAX_TIMERS; i++) begin
            if (r_used[i] && r_rank[i] == oldest_rank) begin
                oldest_id = r_id[i];
            end
            if (r_used[i] && r_id[i] == r_try_id) begin
                try_taken = 1'b1;
            end
            if (r_used[i] && r_id[i] == r_tid) begin
                tid_hit  = 1'b1;
                tid_slot = SLOT_W'(i);
            end
            if (r_used[i] && r_rank[i] == r_pos[SLOT_W-1:0]) begin
                poll_slot = SLOT_W'(i);
            end
        end
    end

    // Shared fire and wait unit.
    assign start_dl    = sat_add(r_now, r_delay);
    assign poll_dl     = r_deadline[poll_slot];
    assign poll_fire   = (poll_dl != '0) && (r_now >= poll_dl);
    assign poll_new_dl = !poll_fire ? poll_dl :
                         (r_period[poll_slot] != '0) ? sat_add(poll_dl, r_period[poll_slot]) :
                         '0;
    assign ev_wait     = r_ev_dl - r_now;
    assign ev_less     = !r_nt[LIMIT_W-1] &&
                         (ev_wait < {{(TIME_W - LIMIT_W){1'b0}}, r_nt});
    assign next_try    = (r_try_id >= ID_W'(ID_LIMIT)) ? '0 : r_try_id + ID_W'(1);

    // Sequencer and table updates.
    always_ff @(posedge i_clk) begin
        o_valid        <= 1'b0;
        o_kind         <= KIND_ACK;
        o_result_id    <= '0;
        o_found        <= 1'b0;
        o_next_timeout <= '0;
        o_fired_count  <= '0;
        o_last         <= 1'b0;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_count    <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd      <= i_command;
                        r_now      <= i_now_ms;
                        r_tid      <= i_timer_id;
                        r_delay    <= i_delay_ms;
                        r_per      <= i_period_ms;
                        r_nt       <= i_timeout_limit;
                        r_due      <= 1'b0;
                        r_pos      <= '0;
                        r_fired    <= '0;
                        r_tries    <= '0;
                        r_ev_valid <= 1'b0;
                        r_try_id   <= (oldest_id >= ID_W'(ID_LIMIT)) ? '0
                                                                     : oldest_id + ID_W'(1);
                        case (i_command)
                            CMD_START: r_state <= S_START;
                            CMD_POLL:  r_state <= S_POLL;
                            default:   r_state <= S_RS;
                        endcase
                    end
                end
                S_START: begin
                    if (r_count == CNT_W'(MAX_TIMERS) ||
                        (r_count != '0 && try_taken && r_tries == TRY_W'(ID_LIMIT))) begin
                        o_valid <= 1'b1;
                        o_kind  <= KIND_START_FAIL;
                        o_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_count != '0 && try_taken) begin
                        r_try_id <= next_try;
                        r_tries  <= r_tries + TRY_W'(1);
                    end else begin
                        // Commit the new timer as the newest in the slot it takes.
                        for (int i = 0; i < MAX_TIMERS; i++) begin
                            if (r_used[i]) begin
                                r_rank[i] <= r_rank[i] + SLOT_W'(1);
                            end
                        end
                        r_used[free_slot]     <= 1'b1;
                        r_rank[free_slot]     <= '0;
                        r_id[free_slot]       <= (r_count == '0) ? '0 : r_try_id;
                        r_deadline[free_slot] <= start_dl;
                        r_period[free_slot]   <= r_per;
                        r_count               <= r_count + CNT_W'(1);
                        o_valid     <= 1'b1;
                        o_kind      <= KIND_STARTED;
                        o_result_id <= (r_count == '0) ? '0 : r_try_id;
                        o_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_RS: begin
                    if (tid_hit) begin
                        if (r_cmd == CMD_REARM) begin
                            r_deadline[tid_slot] <= start_dl;
                            r_period[tid_slot]   <= r_per;
                        end else begin
                            // Close the gap in the age ranks behind the removed timer.
                            for (int i = 0; i < MAX_TIMERS; i++) begin
                                if (r_used[i] && r_rank[i] > r_rank[tid_slot]) begin
                                    r_rank[i] <= r_rank[i] - SLOT_W'(1);
                                end
                            end
                            r_used[tid_slot] <= 1'b0;
                            r_count          <= r_count - CNT_W'(1);
                        end
                    end
                    o_valid <= 1'b1;
                    o_kind  <= KIND_ACK;
                    o_found <= tid_hit;
                    o_last  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_POLL: begin
                    // Wait check on the deadline settled in the previous cycle.
                    if (r_ev_valid && r_ev_dl != '0) begin
                        if (r_now >= r_ev_dl) begin
                            r_due <= 1'b1;
                        end else if (ev_less) begin
                            r_nt <= LIMIT_W'(ev_wait);
                        end
                    end
                    if (r_pos < r_count) begin
                        // Fire the timer at this age rank if it is due.
                        r_deadline[poll_slot] <= poll_new_dl;
                        r_ev_dl    <= poll_new_dl;
                        r_ev_valid <= 1'b1;
                        r_pos      <= r_pos + CNT_W'(1);
                        if (poll_fire) begin
                            o_valid     <= 1'b1;
                            o_kind      <= KIND_FIRED;
                            o_result_id <= r_id[poll_slot];
                            r_fired     <= r_fired + CNT_W'(1);
                        end
                    end else if (r_ev_valid) begin
                        r_ev_valid <= 1'b0;
                    end else begin
                        o_valid        <= 1'b1;
                        o_kind         <= KIND_POLL_DONE;
                        o_next_timeout <= r_due ? '0 : r_nt;
                        o_fired_count  <= r_fired;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // The final result always closes the command.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> r_state == S_IDLE)
        else $error("final result while sequencer still active");

    // The count follows the slot valid bits.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_count))
        else $error("timer count disagrees with used slots");

    // An accepted command always makes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("accepted command did not raise busy");

    // The table never holds more timers than slots.
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TIMERS))
        else $error("timer count beyond table size");
`endif

endmodule
